[hw/rtl/dss_pkg.sv]
// ----------------------------------------------------------------------------
// dss_pkg: shared types and constants for the disk seek scheduler
// Holds the search token, the broadcast cell control and the FSM state type.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int TRACK_W = 10;
    localparam int SUM_W   = 16;
    localparam int IDX_W   = 6;

    localparam logic [1:0] MODE_FIFO = 2'd0;
    localparam logic [1:0] MODE_SSTF = 2'd1;
    localparam logic [1:0] MODE_UP   = 2'd2;
    localparam logic [1:0] MODE_DOWN = 2'd3;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_START = 1'b1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_RUN  = 1'b1;

    localparam logic [TRACK_W-1:0] START_TRACK_RST = 10'd53;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    // best candidate so far, handed from cell to cell
    typedef struct packed {
        logic               found;
        logic               cls;
        logic [TRACK_W-1:0] span;
        logic [IDX_W-1:0]   idx;
        logic [TRACK_W-1:0] track;
    } t_token;

    // broadcast control shared by all cells
    typedef struct packed {
        logic               clr;
        logic [1:0]         mode;
        logic [TRACK_W-1:0] head;
        logic [TRACK_W-1:0] wr_track;
    } t_cell_ctl;

endpackage

[hw/rtl/dss_cell.sv]
// ----------------------------------------------------------------------------
// dss_cell: one request slot of the scheduler chain
// Holds one track and its served mark, merges itself into the passing token.
// ----------------------------------------------------------------------------
module dss_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dss_pkg::t_cell_ctl i_ctl,
    input  logic               i_wr,
    input  logic               i_mark,
    input  logic [5:0]         i_index,
    input  dss_pkg::t_token    i_tok,
    output dss_pkg::t_token    o_tok
);
    import dss_pkg::*;

    logic               r_valid;
    logic               r_served;
    logic [TRACK_W-1:0] r_track;
    t_token             r_tok;
    t_token             n_tok;
    logic               own_ok;
    logic               own_cls;
    logic [TRACK_W-1:0] own_dist;

    always_comb begin
        own_ok = r_valid && !r_served;
        unique case (i_ctl.mode)
            MODE_UP:   own_cls = (r_track < i_ctl.head);
            MODE_DOWN: own_cls = (r_track > i_ctl.head);
            default:   own_cls = 1'b0;
        endcase
        if (i_ctl.mode == MODE_FIFO) begin
            own_dist = '0;
        end else if (r_track >= i_ctl.head) begin
            own_dist = r_track - i_ctl.head;
        end else begin
            own_dist = i_ctl.head - r_track;
        end
        // strict compare: the earlier cell keeps a tie
        if (own_ok && (!i_tok.found || {own_cls, own_dist} < {i_tok.cls, i_tok.span})) begin
            n_tok = '{found: 1'b1, cls: own_cls, span: own_dist, idx: i_index,
                      track: r_track};
        end else begin
            n_tok = i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_served <= 1'b0;
            r_tok    <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_ctl.clr) begin
                r_valid  <= 1'b0;
                r_served <= 1'b0;
            end else begin
                if (i_wr) begin
                    r_valid <= 1'b1;
                end
                if (i_mark) begin
                    r_served <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_track <= i_ctl.wr_track;
        end
    end

    assign o_tok = r_tok;

endmodule

[hw/rtl/disk_seek_scheduler.sv]
// ----------------------------------------------------------------------------
// disk_seek_scheduler: FCFS, SSTF and LOOK disk request ordering
// Loads track requests into a chain of cells and emits the service order.
// ----------------------------------------------------------------------------
// A load writes the next free cell. A run of n requests finds each result by
// walking the search token once across the whole cell chain and then serving
// its winner, so results come out one per served request, in service order.
// An empty run answers straight from idle, without a scan. Results cannot be stalled.
// Reset (synchronous, active low) empties the queue, sets mode 0, start 53.
// ----------------------------------------------------------------------------
module disk_seek_scheduler #(
    parameter int DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_action,
    input  logic [dss_pkg::TRACK_W-1:0] i_track,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [dss_pkg::TRACK_W-1:0] i_cfg_data,
    output logic                        o_valid,
    output logic [dss_pkg::TRACK_W-1:0] o_served_track,
    output logic [dss_pkg::TRACK_W-1:0] o_seek_distance,
    output logic [dss_pkg::SUM_W-1:0]   o_total_movement,
    output logic                        o_last,
    output logic                        o_status
);
    import dss_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // configuration registers
    logic [1:0]         r_mode;
    logic [TRACK_W-1:0] r_start_track;

    // control state
    t_state             r_state,  n_state;
    logic [CNT_W-1:0]   r_count,  n_count;   // requests loaded
    logic [CNT_W-1:0]   r_served, n_served;  // results given in this run
    logic [CNT_W-1:0]   r_cnt,    n_cnt;     // cycles since the last update
    logic [TRACK_W-1:0] r_head,   n_head;
    logic [SUM_W-1:0]   r_sum,    n_sum;

    // result register
    logic               r_ovalid, n_ovalid;
    logic [TRACK_W-1:0] r_otrack, n_otrack;
    logic [TRACK_W-1:0] r_odist,  n_odist;
    logic [SUM_W-1:0]   r_osum,   n_osum;
    logic               r_olast,  n_olast;
    logic               r_ostat,  n_ostat;

    t_cell_ctl          ctl;
    logic               clr_en;
    logic               wr_en;
    logic               mark_en;
    logic [DEPTH-1:0]   cell_wr;
    logic [DEPTH-1:0]   cell_mark;
    t_token             tok [0:DEPTH];
    t_token             best;
    logic [TRACK_W-1:0] step_dist;
    logic               accept;

    assign accept = start && (r_state == S_IDLE);
    assign best   = tok[DEPTH];

    always_comb begin
        if (best.track >= r_head) begin
            step_dist = best.track - r_head;
        end else begin
            step_dist = r_head - best.track;
        end
    end

    // next state and control
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_served = r_served;
        n_cnt    = r_cnt;
        n_head   = r_head;
        n_sum    = r_sum;
        n_ovalid = 1'b0;
        n_otrack = r_otrack;
        n_odist  = r_odist;
        n_osum   = r_osum;
        n_olast  = r_olast;
        n_ostat  = r_ostat;
        wr_en    = 1'b0;
        mark_en  = 1'b0;
        clr_en   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_LOAD) begin
                        // drop loads once the queue is full
                        if (r_count < CNT_W'(DEPTH)) begin
                            wr_en   = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end else if (r_count == '0) begin
                        n_ovalid = 1'b1;
                        n_otrack = '0;
                        n_odist  = '0;
                        n_osum   = '0;
                        n_olast  = 1'b1;
                        n_ostat  = 1'b1;
                    end else begin
                        n_head   = r_start_track;
                        n_sum    = '0;
                        n_served = '0;
                        n_cnt    = '0;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_cnt == CNT_W'(DEPTH)) begin
                    // token has crossed the whole chain: serve its winner
                    mark_en  = 1'b1;
                    n_ovalid = 1'b1;
                    n_otrack = best.track;
                    n_odist  = step_dist;
                    n_osum   = r_sum + SUM_W'(step_dist);
                    n_ostat  = 1'b0;
                    n_olast  = (r_served + 1'b1 == r_count);
                    n_sum    = r_sum + SUM_W'(step_dist);
                    n_head   = best.track;
                    n_served = r_served + 1'b1;
                    n_cnt    = '0;
                    if (r_served + 1'b1 == r_count) begin
                        clr_en  = 1'b1;
                        n_count = '0;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign ctl = '{clr: clr_en, mode: r_mode, head: r_head, wr_track: i_track};

    // per-slot write and served strobes
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_wr[i]   = wr_en && (r_count == CNT_W'(i));
            cell_mark[i] = mark_en && (best.idx == IDX_W'(i));
        end
    end

    assign tok[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        dss_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_wr    (cell_wr[g]),
            .i_mark  (cell_mark[g]),
            .i_index (IDX_W'(g)),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_served      <= '0;
            r_cnt         <= '0;
            r_ovalid      <= 1'b0;
            r_mode        <= MODE_FIFO;
            r_start_track <= START_TRACK_RST;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_served <= n_served;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODE:  r_mode        <= i_cfg_data[1:0];
                    CFG_START: r_start_track <= i_cfg_data;
                    default:   r_mode        <= r_mode;
                endcase
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_head   <= n_head;
        r_sum    <= n_sum;
        r_otrack <= n_otrack;
        r_odist  <= n_odist;
        r_osum   <= n_osum;
        r_olast  <= n_olast;
        r_ostat  <= n_ostat;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_served_track   = r_otrack;
    assign o_seek_distance  = r_odist;
    assign o_total_movement = r_osum;
    assign o_last           = r_olast;
    assign o_status         = r_ostat;

`ifndef NO_ASSERTIONS
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_count != '0)
        else $error("scan with empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("scan counter out of range");
    a_winner_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mark_en |-> best.found)
        else $error("no unserved request found");
    a_served_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !r_ostat |-> $past(r_state == S_SCAN))
        else $error("served result outside a scan");
`endif

endmodule
